// ===== rtl/core/bdhd_pkg.sv =====
package bdhd_pkg;

    // button count limits and default
    localparam int BUTTONS_DEFAULT = 4;
    localparam int BUTTONS_MAX     = 16;

    // fixed field widths
    localparam int MODE_W     = 2;
    localparam int PIN_W      = 4;
    localparam int SLOT_W     = 2;
    localparam int OUT_SLOTS  = 4;
    localparam int DEBOUNCE_W = 10;
    localparam int HOLD_W     = 16;
    localparam int SINCE_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd50;
    localparam logic [HOLD_W-1:0]     HOLD_RESET     = 16'd2000;
    localparam logic [SINCE_W-1:0]    SINCE_MAX      = 11'd2047;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK          = 2'd0,
        MODE_CLEAR_FLAGS   = 2'd1,
        MODE_FORCE_RELEASE = 2'd2,
        MODE_IGNORE        = 2'd3
    } mode_t;

    typedef enum logic [SLOT_W-1:0] {
        ST_RELEASED = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_HELD     = 2'd2
    } btn_state_t;

    typedef enum logic [SLOT_W-1:0] {
        FL_CLEAR   = 2'd0,
        FL_PRESSED = 2'd1,
        FL_HELD    = 2'd2
    } flag_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_HOLD     = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PIN_W-1:0]  pin_levels;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W*OUT_SLOTS-1:0] action_flags;
        logic [OUT_SLOTS-1:0]        press_events;
        logic [OUT_SLOTS-1:0]        hold_events;
        logic [SLOT_W*OUT_SLOTS-1:0] button_states;
    } out_item_t;

endpackage

// ===== rtl/core/bdhd_item_if.sv =====
interface bdhd_item_if;
    logic               valid;
    logic               ready;
    bdhd_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bdhd_result_if.sv =====
interface bdhd_result_if;
    logic                valid;
    logic                ready;
    bdhd_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bdhd_cfg_if.sv =====
interface bdhd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bdhd_pkg::CFG_IDX_W-1:0]      index;
    logic [bdhd_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/button_debounce_hold_detector.sv =====
// a result is registered in the output stage when its item is accepted, or in the skid entry if the output is stalled
// throughput: one item per cycle while results are taken, set by the single per-button update stage
// a stalled result lets one more item into the skid entry, then the input stalls
// input reopens the cycle after the stalled result is taken
// reset: all buttons released, timers stopped and zeroed, flags clear,
// debounce_ms = 50, hold_ms = 2000, output stage empty
module button_debounce_hold_detector #(
    parameter int BUTTONS = bdhd_pkg::BUTTONS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bdhd_item_if.sink            item,
    bdhd_result_if.source        result,
    bdhd_cfg_if.sink             cfg
);

    // configuration registers
    logic [bdhd_pkg::DEBOUNCE_W-1:0] debounce_reg;
    logic [bdhd_pkg::HOLD_W-1:0]     hold_reg;

    // per-button state
    bdhd_pkg::btn_state_t            st_reg    [BUTTONS];
    bdhd_pkg::btn_state_t            st_next   [BUTTONS];
    logic [bdhd_pkg::SINCE_W-1:0]    since_reg [BUTTONS];
    logic [bdhd_pkg::SINCE_W-1:0]    since_next[BUTTONS];
    logic [bdhd_pkg::HOLD_W-1:0]     cnt_reg   [BUTTONS];
    logic [bdhd_pkg::HOLD_W-1:0]     cnt_next  [BUTTONS];
    logic                            run_reg   [BUTTONS];
    logic                            run_next  [BUTTONS];
    bdhd_pkg::flag_t                 flag_reg  [BUTTONS];
    bdhd_pkg::flag_t                 flag_next [BUTTONS];
    logic [BUTTONS-1:0]              press_ev;
    logic [BUTTONS-1:0]              hold_ev;
    logic [BUTTONS-1:0]              released;

    // output stage: main register plus skid entry
    logic                            out_valid_reg;
    bdhd_pkg::out_item_t             out_data_reg;
    logic                            skid_valid_reg;
    bdhd_pkg::out_item_t             skid_data_reg;
    bdhd_pkg::out_item_t             res_new;

    logic                            accept;
    bdhd_pkg::mode_t                 mode;

    // input side stays open until the skid entry is occupied
    assign item.ready = !skid_valid_reg;
    assign accept     = item.valid && item.ready;
    assign mode       = bdhd_pkg::mode_t'(item.data.mode);

    // configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= bdhd_pkg::DEBOUNCE_RESET;
            hold_reg     <= bdhd_pkg::HOLD_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (bdhd_pkg::cfg_index_t'(cfg.index))
                bdhd_pkg::REG_DEBOUNCE:
                    debounce_reg <= cfg.data[bdhd_pkg::DEBOUNCE_W-1:0];
                bdhd_pkg::REG_HOLD:
                    hold_reg <= cfg.data[bdhd_pkg::HOLD_W-1:0];
                default:
                begin
                    // writes to unused indexes are dropped
                end
            endcase
        end
    end

    // pins beyond the pin field read as released (pull-up)
    generate
        for (genvar g = 0; g < BUTTONS; g++)
        begin : g_pin
            if (g < bdhd_pkg::PIN_W)
            begin : g_real
                assign released[g] = item.data.pin_levels[g];
            end
            else
            begin : g_tied
                assign released[g] = 1'b1;
            end
        end
    endgenerate

    // per-button update, each button independent of the others
    always_comb
    begin
        for (int i = 0; i < BUTTONS; i++)
        begin
            st_next[i]    = st_reg[i];
            since_next[i] = since_reg[i];
            cnt_next[i]   = cnt_reg[i];
            run_next[i]   = run_reg[i];
            flag_next[i]  = flag_reg[i];
            press_ev[i]   = 1'b0;
            hold_ev[i]    = 1'b0;

            if (accept)
            begin
                unique case (mode)
                    bdhd_pkg::MODE_TICK:
                    begin
                        // debounced transition, only once the quiet time has passed
                        if (since_reg[i] > {1'b0, debounce_reg})
                        begin
                            unique case (st_reg[i])
                                bdhd_pkg::ST_RELEASED:
                                begin
                                    if (!released[i])
                                    begin
                                        st_next[i]    = bdhd_pkg::ST_PRESSED;
                                        since_next[i] = '0;
                                        run_next[i]   = 1'b1;
                                    end
                                end
                                bdhd_pkg::ST_PRESSED:
                                begin
                                    // short press completes on release
                                    if (released[i])
                                    begin
                                        st_next[i]    = bdhd_pkg::ST_RELEASED;
                                        since_next[i] = '0;
                                        run_next[i]   = 1'b0;
                                        cnt_next[i]   = '0;
                                        flag_next[i]  = bdhd_pkg::FL_PRESSED;
                                        press_ev[i]   = 1'b1;
                                    end
                                end
                                bdhd_pkg::ST_HELD:
                                begin
                                    if (released[i])
                                    begin
                                        st_next[i]    = bdhd_pkg::ST_RELEASED;
                                        since_next[i] = '0;
                                        run_next[i]   = 1'b0;
                                        cnt_next[i]   = '0;
                                        flag_next[i]  = bdhd_pkg::FL_CLEAR;
                                    end
                                end
                                default:
                                begin
                                    st_next[i] = bdhd_pkg::ST_RELEASED;
                                end
                            endcase
                        end

                        // hold timer advances after the update; zero hold time acts as one
                        if (run_next[i])
                        begin
                            if (({1'b0, cnt_next[i]} + 17'd1) >= {1'b0, hold_reg})
                            begin
                                run_next[i]  = 1'b0;
                                cnt_next[i]  = '0;
                                st_next[i]   = bdhd_pkg::ST_HELD;
                                flag_next[i] = bdhd_pkg::FL_HELD;
                                hold_ev[i]   = 1'b1;
                            end
                            else
                            begin
                                cnt_next[i] = cnt_next[i] + 16'd1;
                            end
                        end

                        // saturating time since last change
                        if (since_next[i] != bdhd_pkg::SINCE_MAX)
                        begin
                            since_next[i] = since_next[i] + 11'd1;
                        end
                    end
                    bdhd_pkg::MODE_CLEAR_FLAGS:
                    begin
                        flag_next[i] = bdhd_pkg::FL_CLEAR;
                    end
                    bdhd_pkg::MODE_FORCE_RELEASE:
                    begin
                        // timer stops but keeps its count
                        flag_next[i] = bdhd_pkg::FL_CLEAR;
                        st_next[i]   = bdhd_pkg::ST_RELEASED;
                        run_next[i]  = 1'b0;
                    end
                    bdhd_pkg::MODE_IGNORE:
                    begin
                        // no change, result reports current state
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUTTONS; i++)
            begin
                st_reg[i]    <= bdhd_pkg::ST_RELEASED;
                since_reg[i] <= '0;
                cnt_reg[i]   <= '0;
                run_reg[i]   <= 1'b0;
                flag_reg[i]  <= bdhd_pkg::FL_CLEAR;
            end
        end
        else
        begin
            for (int i = 0; i < BUTTONS; i++)
            begin
                st_reg[i]    <= st_next[i];
                since_reg[i] <= since_next[i];
                cnt_reg[i]   <= cnt_next[i];
                run_reg[i]   <= run_next[i];
                flag_reg[i]  <= flag_next[i];
            end
        end
    end

    // result packing; buttons beyond the output fields are dropped, missing ones read zero
    generate
        for (genvar s = 0; s < bdhd_pkg::OUT_SLOTS; s++)
        begin : g_slot
            if (s < BUTTONS)
            begin : g_used
                assign res_new.action_flags[bdhd_pkg::SLOT_W*s +: bdhd_pkg::SLOT_W]  =
                    flag_next[s];
                assign res_new.button_states[bdhd_pkg::SLOT_W*s +: bdhd_pkg::SLOT_W] =
                    st_next[s];
                assign res_new.press_events[s] = press_ev[s];
                assign res_new.hold_events[s]  = hold_ev[s];
            end
            else
            begin : g_empty
                assign res_new.action_flags[bdhd_pkg::SLOT_W*s +: bdhd_pkg::SLOT_W]  = '0;
                assign res_new.button_states[bdhd_pkg::SLOT_W*s +: bdhd_pkg::SLOT_W] = '0;
                assign res_new.press_events[s] = 1'b0;
                assign res_new.hold_events[s]  = 1'b0;
            end
        end
    endgenerate

    // output stage control: a stalled result parks the next one in the skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !result.ready)
        begin
            if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= accept;
        end
    end

    // output stage payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !result.ready)
        begin
            if (accept)
            begin
                skid_data_reg <= res_new;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (accept)
        begin
            out_data_reg <= res_new;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

// ===== rtl/core/bdhd_checker.sv =====
module bdhd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       res_valid,
    input logic                       res_ready,
    input bdhd_pkg::out_item_t        res_data
);

    // a button cannot finish a short press and reach hold time in one transaction
    a_press_hold_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_data.press_events & res_data.hold_events) == '0))
        else $error("press and hold event on the same button");

    // a stalled result holds until taken
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
        else $error("stalled result changed");

    generate
        for (genvar s = 0; s < bdhd_pkg::OUT_SLOTS; s++)
        begin : g_slot
            // hold event leaves the button held with the held flag
            a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
                (res_valid && res_data.hold_events[s]) |->
                ((res_data.button_states[bdhd_pkg::SLOT_W*s +: bdhd_pkg::SLOT_W]
                    == bdhd_pkg::ST_HELD) &&
                 (res_data.action_flags[bdhd_pkg::SLOT_W*s +: bdhd_pkg::SLOT_W]
                    == bdhd_pkg::FL_HELD)))
                else $error("hold event without held state");

            // press event leaves the button released with the pressed flag
            a_press_state: assert property (@(posedge clk) disable iff (!rst_n)
                (res_valid && res_data.press_events[s]) |->
                ((res_data.button_states[bdhd_pkg::SLOT_W*s +: bdhd_pkg::SLOT_W]
                    == bdhd_pkg::ST_RELEASED) &&
                 (res_data.action_flags[bdhd_pkg::SLOT_W*s +: bdhd_pkg::SLOT_W]
                    == bdhd_pkg::FL_PRESSED)))
                else $error("press event without pressed flag");
        end
    endgenerate

endmodule

bind button_debounce_hold_detector bdhd_checker u_bdhd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);

// ===== tb/bdhd_button_checker.sv =====
`timescale 1ns / 1ps

module bdhd_button_checker #(
    parameter int BUTTONS = bdhd_pkg::BUTTONS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    bdhd_item_if         item,
    bdhd_result_if       result,
    bdhd_cfg_if          cfg,
    output int unsigned  mismatches,
    output int unsigned  awaiting,
    output int unsigned  reports_checked,
    output int unsigned  press_total,
    output int unsigned  hold_total
);

    // shadow copy of the button bank
    bdhd_pkg::btn_state_t               btn_state  [BUTTONS];
    logic [bdhd_pkg::SINCE_W-1:0]       since_chg  [BUTTONS];
    logic [bdhd_pkg::HOLD_W-1:0]        hold_cnt   [BUTTONS];
    logic                               hold_run   [BUTTONS];
    bdhd_pkg::flag_t                    btn_flag   [BUTTONS];
    logic [bdhd_pkg::DEBOUNCE_W-1:0]    debounce_cfg;
    logic [bdhd_pkg::HOLD_W-1:0]        hold_cfg;

    bdhd_pkg::out_item_t expected_reports[$];

    // advance the shadow bank by one item and build the report it should produce
    function automatic bdhd_pkg::out_item_t step_buttons(input bdhd_pkg::in_item_t it);
        bdhd_pkg::out_item_t          rep;
        logic                         released;
        logic [bdhd_pkg::HOLD_W:0]    next_cnt;
        rep = '0;
        case (it.mode)
            bdhd_pkg::MODE_TICK:
            begin
                for (int i = 0; i < BUTTONS; i++)
                begin
                    released = (i < bdhd_pkg::PIN_W) ? it.pin_levels[i] : 1'b1;
                    if (since_chg[i] > {1'b0, debounce_cfg})
                    begin
                        case (btn_state[i])
                            bdhd_pkg::ST_RELEASED:
                            begin
                                if (!released)
                                begin
                                    btn_state[i] = bdhd_pkg::ST_PRESSED;
                                    since_chg[i] = '0;
                                    hold_run[i]  = 1'b1;
                                end
                            end
                            bdhd_pkg::ST_PRESSED:
                            begin
                                if (released)
                                begin
                                    btn_state[i] = bdhd_pkg::ST_RELEASED;
                                    since_chg[i] = '0;
                                    hold_run[i]  = 1'b0;
                                    hold_cnt[i]  = '0;
                                    btn_flag[i]  = bdhd_pkg::FL_PRESSED;
                                    if (i < bdhd_pkg::OUT_SLOTS)
                                        rep.press_events[i] = 1'b1;
                                end
                            end
                            bdhd_pkg::ST_HELD:
                            begin
                                if (released)
                                begin
                                    btn_state[i] = bdhd_pkg::ST_RELEASED;
                                    since_chg[i] = '0;
                                    btn_flag[i]  = bdhd_pkg::FL_CLEAR;
                                    hold_run[i]  = 1'b0;
                                    hold_cnt[i]  = '0;
                                end
                            end
                            default: btn_state[i] = bdhd_pkg::ST_RELEASED;
                        endcase
                    end
                    // hold timer, a zero hold time fires on the first running tick
                    if (hold_run[i])
                    begin
                        next_cnt = {1'b0, hold_cnt[i]} + 17'd1;
                        if (next_cnt >= {1'b0, hold_cfg})
                        begin
                            hold_run[i]  = 1'b0;
                            hold_cnt[i]  = '0;
                            btn_state[i] = bdhd_pkg::ST_HELD;
                            btn_flag[i]  = bdhd_pkg::FL_HELD;
                            if (i < bdhd_pkg::OUT_SLOTS)
                                rep.hold_events[i] = 1'b1;
                        end
                        else
                            hold_cnt[i] = next_cnt[bdhd_pkg::HOLD_W-1:0];
                    end
                    if (since_chg[i] != bdhd_pkg::SINCE_MAX)
                        since_chg[i] = since_chg[i] + 11'd1;
                end
            end
            bdhd_pkg::MODE_CLEAR_FLAGS:
            begin
                for (int i = 0; i < BUTTONS; i++)
                    btn_flag[i] = bdhd_pkg::FL_CLEAR;
            end
            bdhd_pkg::MODE_FORCE_RELEASE:
            begin
                // timer count is kept on purpose
                for (int i = 0; i < BUTTONS; i++)
                begin
                    btn_flag[i]  = bdhd_pkg::FL_CLEAR;
                    btn_state[i] = bdhd_pkg::ST_RELEASED;
                    hold_run[i]  = 1'b0;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < BUTTONS && i < bdhd_pkg::OUT_SLOTS; i++)
        begin
            rep.action_flags[bdhd_pkg::SLOT_W*i +: bdhd_pkg::SLOT_W]  = btn_flag[i];
            rep.button_states[bdhd_pkg::SLOT_W*i +: bdhd_pkg::SLOT_W] = btn_state[i];
        end
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        bdhd_pkg::out_item_t want;
        bdhd_pkg::out_item_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < BUTTONS; i++)
            begin
                btn_state[i] = bdhd_pkg::ST_RELEASED;
                since_chg[i] = '0;
                hold_cnt[i]  = '0;
                hold_run[i]  = 1'b0;
                btn_flag[i]  = bdhd_pkg::FL_CLEAR;
            end
            debounce_cfg = bdhd_pkg::DEBOUNCE_RESET;
            hold_cfg     = bdhd_pkg::HOLD_RESET;
            expected_reports.delete();
            mismatches      = 0;
            reports_checked = 0;
            press_total     = 0;
            hold_total      = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got = result.data;
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    $error("report transaction with no item outstanding: %h", got);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    reports_checked++;
                    press_total += $countones(want.press_events);
                    hold_total  += $countones(want.hold_events);
                    if (got.action_flags !== want.action_flags)
                    begin
                        mismatches++;
                        $error("action_flags: expected %h, got %h",
                               want.action_flags, got.action_flags);
                    end
                    if (got.press_events !== want.press_events)
                    begin
                        mismatches++;
                        $error("press_events: expected %h, got %h",
                               want.press_events, got.press_events);
                    end
                    if (got.hold_events !== want.hold_events)
                    begin
                        mismatches++;
                        $error("hold_events: expected %h, got %h",
                               want.hold_events, got.hold_events);
                    end
                    if (got.button_states !== want.button_states)
                    begin
                        mismatches++;
                        $error("button_states: expected %h, got %h",
                               want.button_states, got.button_states);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    bdhd_pkg::REG_DEBOUNCE:
                        debounce_cfg = cfg.data[bdhd_pkg::DEBOUNCE_W-1:0];
                    bdhd_pkg::REG_HOLD:
                        hold_cfg     = cfg.data[bdhd_pkg::HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                expected_reports.push_back(step_buttons(item.data));
        end
        awaiting = expected_reports.size();
    end

endmodule

// ===== tb/button_debounce_hold_detector_tb.sv =====
`timescale 1ns / 1ps

module button_debounce_hold_detector_tb;

    localparam int BUTTONS         = bdhd_pkg::BUTTONS_DEFAULT;
    localparam int PIN_W           = bdhd_pkg::PIN_W;
    // cycles without any transaction before the run is declared hung
    localparam int IDLE_LIMIT      = 2000;
    // long receiver hold-off, long enough to fill the output stage and stall the input
    localparam int HOLD_OFF_CYCLES = 64;
    // an index that maps to no register, written to show it is harmless
    localparam logic [bdhd_pkg::CFG_IDX_W-1:0] SPARE_REG = 2'd3;
    localparam int JUNK_W          = bdhd_pkg::CFG_DATA_W - bdhd_pkg::DEBOUNCE_W;

    logic clk;
    logic rst_n;

    bdhd_item_if   item_ch ();
    bdhd_result_if result_ch ();
    bdhd_cfg_if    cfg_ch ();

    int unsigned mismatches;
    int unsigned awaiting;
    int unsigned reports_checked;
    int unsigned press_total;
    int unsigned hold_total;

    // idling controls shared by the driving processes
    int unsigned gap_pct;
    int unsigned stall_pct;
    bit          calm;
    bit          hold_off_req;
    int unsigned items_sent;
    int unsigned settings_used;

    // per-button pin pattern: current level and ticks left before it flips
    logic [PIN_W-1:0] levels;
    int unsigned      run_left [PIN_W];

    button_debounce_hold_detector #(
        .BUTTONS (BUTTONS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    bdhd_button_checker #(
        .BUTTONS (BUTTONS)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .result          (result_ch),
        .cfg             (cfg_ch),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .reports_checked (reports_checked),
        .press_total     (press_total),
        .hold_total      (hold_total)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin : result_sink
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                // hold off while the sender keeps offering, block must back up
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                result_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // watchdog: ends the run when no transaction happens for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) ||
                (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d reports still due",
                 IDLE_LIMIT, awaiting);
        $display("** button_debounce_hold_detector: FAILED **");
        $finish;
    end

    // offer one item, optionally after a random gap; returns right after its transaction
    task automatic offer(input bdhd_pkg::mode_t mode, input logic [PIN_W-1:0] pins);
        int unsigned gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            item_ch.valid <= 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= '{mode: mode, pin_levels: pins};
        do @(posedge clk); while (!item_ch.ready);
        items_sent++;
    endtask

    // drop valid and wait until every report has come back
    task automatic drain();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
        // allow a little margin
        repeat (2) @(negedge clk);
    endtask

    // one register write transaction, only issued while the block is idle
    task automatic write_reg(input logic [bdhd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bdhd_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // random items: mostly ticks with held pin levels, some housekeeping and bounce noise
    task automatic press_pattern(input int unsigned count, input int unsigned span);
        int unsigned      pick;
        logic [PIN_W-1:0] pins;
        for (int k = 0; k < count; k++)
        begin
            for (int b = 0; b < PIN_W; b++)
            begin
                if (run_left[b] == 0)
                begin
                    levels[b]   = ~levels[b];
                    run_left[b] = $urandom_range(1, span);
                end
                else
                    run_left[b]--;
            end
            pins = levels;
            // short glitches that the debounce window should swallow
            if ($urandom_range(0, 9) == 0)
                pins ^= PIN_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 4)
                offer(bdhd_pkg::MODE_CLEAR_FLAGS, PIN_W'($urandom));
            else if (pick < 6)
                offer(bdhd_pkg::MODE_FORCE_RELEASE, PIN_W'($urandom));
            else if (pick < 8)
                offer(bdhd_pkg::MODE_IGNORE, PIN_W'($urandom));
            else
                offer(bdhd_pkg::MODE_TICK, pins);
        end
    endtask

    // retune both registers while idle, then run random items at that setting
    task automatic run_setting(input int unsigned debounce, input int unsigned hold_len,
                               input int unsigned count, input int unsigned gap,
                               input int unsigned stall, input bit with_hold_off);
        int unsigned span;
        drain();
        // upper data bits are junk, the register keeps only its own width
        write_reg(bdhd_pkg::REG_DEBOUNCE,
                  {JUNK_W'($urandom), debounce[bdhd_pkg::DEBOUNCE_W-1:0]});
        write_reg(bdhd_pkg::REG_HOLD, hold_len[bdhd_pkg::HOLD_W-1:0]);
        settings_used++;
        gap_pct   = gap;
        stall_pct = stall;
        // runs long enough to reach the hold time, short ones to bounce
        span = 2 * (debounce + hold_len) + 4;
        if (span > 300)
            span = 300;
        if (with_hold_off)
        begin
            press_pattern(count / 5, span);
            hold_off_req = 1'b1;
            press_pattern(count - count / 5, span);
        end
        else
            press_pattern(count, span);
    endtask

    initial
    begin : stimulus
        int unsigned rand_db;
        int unsigned rand_hold;

        rst_n         = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = bdhd_pkg::REG_DEBOUNCE;
        cfg_ch.data   = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        calm          = 1'b0;
        hold_off_req  = 1'b0;
        items_sent    = 0;
        settings_used = 0;
        levels        = '1;
        for (int b = 0; b < PIN_W; b++)
            run_left[b] = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: debounce window not yet open, nothing may change
        offer(bdhd_pkg::MODE_IGNORE, 4'hF);
        offer(bdhd_pkg::MODE_TICK, 4'h0);
        offer(bdhd_pkg::MODE_CLEAR_FLAGS, 4'h5);
        offer(bdhd_pkg::MODE_FORCE_RELEASE, 4'hA);

        // shortest debounce and a short hold for the directed walk
        drain();
        write_reg(bdhd_pkg::REG_DEBOUNCE, '0);
        write_reg(bdhd_pkg::REG_HOLD, 16'd3);
        write_reg(SPARE_REG, '1);
        settings_used++;

        offer(bdhd_pkg::MODE_TICK, 4'hF);          // all released, opens the window
        offer(bdhd_pkg::MODE_TICK, 4'h0);          // all pressed, timers start
        offer(bdhd_pkg::MODE_TICK, 4'h0);          // still pressed, timers count
        offer(bdhd_pkg::MODE_TICK, 4'hF);          // short press completes
        offer(bdhd_pkg::MODE_CLEAR_FLAGS, 4'hF);   // pressed flags cleared
        offer(bdhd_pkg::MODE_TICK, 4'h0);          // press again
        offer(bdhd_pkg::MODE_TICK, 4'h0);
        offer(bdhd_pkg::MODE_TICK, 4'h0);          // hold time reached, held
        offer(bdhd_pkg::MODE_TICK, 4'h0);          // stays held, timer stopped
        offer(bdhd_pkg::MODE_CLEAR_FLAGS, 4'h0);   // held flags cleared, state kept
        offer(bdhd_pkg::MODE_TICK, 4'hF);          // release from held
        offer(bdhd_pkg::MODE_TICK, 4'h0);          // press, timer at one
        offer(bdhd_pkg::MODE_FORCE_RELEASE, 4'h0); // forced release keeps the count
        offer(bdhd_pkg::MODE_TICK, 4'h0);          // press resumes from kept count
        offer(bdhd_pkg::MODE_TICK, 4'h0);          // held
        offer(bdhd_pkg::MODE_IGNORE, 4'h5);        // ignored, state reported as is
        offer(bdhd_pkg::MODE_TICK, 4'hA);          // mixed levels, half released
        offer(bdhd_pkg::MODE_TICK, 4'h5);          // the other half
        offer(bdhd_pkg::MODE_TICK, 4'hF);

        // random part across several settings, extremes included
        run_setting(0, 1, 120, 10, 6, 1'b0);
        run_setting(1023, 65535, 40, 10, 6, 1'b0);
        run_setting(2, 6, 150, 0, 0, 1'b1);
        run_setting(0, 0, 100, 15, 8, 1'b0);
        run_setting(3, 15, 150, 0, 0, 1'b0);
        run_setting(1, 9, 150, 25, 15, 1'b0);
        rand_db   = $urandom_range(0, 7);
        rand_hold = $urandom_range(1, 40);
        run_setting(rand_db, rand_hold, 150, 12, 10, 1'b0);

        // closing stretch at full rate on both sides
        calm = 1'b1;
        run_setting(5, 25, 150, 0, 0, 1'b0);

        drain();

        $display("covered %0d items over %0d register settings, %0d reports checked",
                 items_sent, settings_used, reports_checked);
        $display("saw %0d short presses and %0d holds, with a long receiver hold-off",
                 press_total, hold_total);
        if (mismatches == 0 && awaiting == 0)
            $display("** button_debounce_hold_detector: PASSED **");
        else
            $display("** button_debounce_hold_detector: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bdhd_pkg.sv
rtl/core/bdhd_item_if.sv
rtl/core/bdhd_result_if.sv
rtl/core/bdhd_cfg_if.sv
rtl/core/button_debounce_hold_detector.sv
rtl/core/bdhd_checker.sv
tb/bdhd_button_checker.sv
tb/button_debounce_hold_detector_tb.sv
